/* hw/rtl/cnpd_pkg.sv */
// Shared types, constants and saturating helpers for the contact normal force unit.
`timescale 1ns / 1ps
package cnpd_pkg;

   localparam int CONTACTS  = 1024;
   localparam int CIDX_W    = $clog2(CONTACTS);
   localparam int DATA_W    = 64;
   localparam int CFG_W     = 63;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [DATA_W-1:0] q_type;

   localparam q_type ONE_Q   = 64'sh0000_0001_0000_0000;
   localparam q_type POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam q_type NEG_MIN = 64'sh8000_0000_0000_0000;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
      q_type      a;
      q_type      b;
   } alu_req_type;

   typedef struct packed {
      logic  done;
      q_type result;
   } alu_rsp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOPE_DIV_TWO,
      CSR_SLOPE_DIV_THREE,
      CSR_SLOPE_DIV_FOUR,
      CSR_KNEE_ONE,
      CSR_KNEE_TWO,
      CSR_KNEE_THREE,
      CSR_YIELD,
      CSR_TENSILE
   } csr_index_type;

   typedef struct packed {
      logic [CIDX_W-1:0] contact_index;
      q_type             indentation;
      logic [CFG_W-1:0]  elastic_stiffness;
      logic [CFG_W-1:0]  equivalent_modulus;
      logic [CFG_W-1:0]  contact_area;
      logic [CFG_W-1:0]  plastic_modulus;
      logic [CFG_W-1:0]  damage_span_factor;
      logic              first_step;
   } req_type;

   typedef struct packed {
      q_type       normal_force;
      q_type       stiffness_ratio;
      logic [32:0] damage;
      logic        damage_written;
      logic        tension_failure;
   } rsp_type;

   // Magnitude of a signed value; the most negative value maps to 2^63.
   function automatic logic [DATA_W-1:0] magof(input q_type x);
      logic [DATA_W-1:0] ux;
      ux = x;
      magof = x[DATA_W-1] ? (~ux + 64'd1) : ux;
   endfunction

   // Signed value from sign and magnitude, saturated to the data range.
   function automatic q_type from_mag(input logic neg, input logic [DATA_W-1:0] m);
      logic [DATA_W-1:0] mm;
      if (neg) begin
         mm = (m > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : m;
         from_mag = q_type'(~mm + 64'd1);
      end else begin
         mm = (m > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
         from_mag = q_type'(mm);
      end
   endfunction

   // Clamp a sum carried one bit wider back into the data range.
   function automatic q_type sat_wide(input logic signed [DATA_W:0] s);
      if (s[DATA_W] != s[DATA_W-1]) begin
         sat_wide = s[DATA_W] ? NEG_MIN : POS_MAX;
      end else begin
         sat_wide = q_type'(s[DATA_W-1:0]);
      end
   endfunction

endpackage

/* hw/rtl/cnpd_alu.sv */
// Shared saturating Q32.32 unit: add, subtract, 4-step multiply, 64-step divide.
`timescale 1ns / 1ps
module cnpd_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  cnpd_pkg::alu_req_type alu_req,
   output cnpd_pkg::alu_rsp_type alu_rsp
);
   import cnpd_pkg::*;

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL,
      A_MFIN,
      A_DIV,
      A_DFIN
   } astate_type;

   astate_type         state_ff;
   logic               done_ff;
   q_type              res_ff;
   logic               neg_ff;
   logic [DATA_W-1:0]  ua_ff, ub_ff;
   logic [127:0]       acc_ff;
   logic [63:0]        prod_ff;
   logic [1:0]         sh_ff;
   logic [5:0]         cnt_ff;
   logic [DATA_W-1:0]  r_ff, lo_ff, q_ff;

   logic [DATA_W-1:0]  ua_in, ub_in;
   logic [31:0]        pa_in, pb_in;
   logic [127:0]       addend_in;
   logic [DATA_W-1:0]  rn_in;
   logic               sub_in;
   logic [DATA_W-1:0]  mfin_in;
   logic               div_short_in;
   logic               done_in;

   always_comb begin
      ua_in = magof(alu_req.a);
      ub_in = magof(alu_req.b);
      // select partial product halves by step
      pa_in = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      pb_in = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      case (sh_ff)
         2'd0:    addend_in = {64'd0, prod_ff};
         2'd1:    addend_in = {32'd0, prod_ff, 32'd0};
         default: addend_in = {prod_ff, 64'd0};
      endcase
      // one restoring divide step
      rn_in  = {r_ff[62:0], lo_ff[63]};
      sub_in = r_ff[63] || (rn_in >= ub_ff);
      mfin_in = (acc_ff[127:96] != 32'd0) ? {DATA_W{1'b1}} : acc_ff[95:32];
      // divide that ends at once on a zero operand or an overflow
      div_short_in = (ua_in == '0) || (ub_in == '0) || ({32'd0, ua_in[63:32]} >= ub_in);
      // completion pulse
      done_in = (state_ff == A_MFIN) || (state_ff == A_DFIN) ||
                ((state_ff == A_IDLE) && alu_req.start &&
                 ((alu_req.op == ALU_ADD) || (alu_req.op == ALU_SUB) ||
                  (alu_req.op == ALU_DIV && div_short_in)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= done_in;
         case (state_ff)
            A_IDLE: begin
               if (alu_req.start) begin
                  neg_ff <= alu_req.a[DATA_W-1] ^ alu_req.b[DATA_W-1];
                  ua_ff  <= ua_in;
                  ub_ff  <= ub_in;
                  case (alu_req.op)
                     ALU_ADD: begin
                        res_ff  <= sat_wide({alu_req.a[DATA_W-1], alu_req.a}
                                            + {alu_req.b[DATA_W-1], alu_req.b});
                     end
                     ALU_SUB: begin
                        res_ff  <= sat_wide({alu_req.a[DATA_W-1], alu_req.a}
                                            - {alu_req.b[DATA_W-1], alu_req.b});
                     end
                     ALU_MUL: begin
                        acc_ff   <= '0;
                        cnt_ff   <= '0;
                        state_ff <= A_MUL;
                     end
                     default: begin
                        if (ua_in == '0) begin
                           res_ff  <= '0;
                        end else if (ub_in == '0) begin
                           res_ff  <= from_mag(alu_req.a[DATA_W-1], {DATA_W{1'b1}});
                        end else if ({32'd0, ua_in[63:32]} >= ub_in) begin
                           res_ff  <= from_mag(alu_req.a[DATA_W-1] ^ alu_req.b[DATA_W-1],
                                               {DATA_W{1'b1}});
                        end else begin
                           r_ff     <= {32'd0, ua_in[63:32]};
                           lo_ff    <= {ua_in[31:0], 32'd0};
                           q_ff     <= '0;
                           cnt_ff   <= '0;
                           state_ff <= A_DIV;
                        end
                     end
                  endcase
               end
            end
            A_MUL: begin
               // product registered, accumulated in the following step
               if (cnt_ff < 6'd4) begin
                  prod_ff <= pa_in * pb_in;
                  sh_ff   <= 2'(cnt_ff[1] + cnt_ff[0]);
               end
               if (cnt_ff != 6'd0) begin
                  acc_ff <= acc_ff + addend_in;
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd4) begin
                  state_ff <= A_MFIN;
               end
            end
            A_MFIN: begin
               res_ff   <= from_mag(neg_ff, mfin_in);
               state_ff <= A_IDLE;
            end
            A_DIV: begin
               r_ff   <= sub_in ? (rn_in - ub_ff) : rn_in;
               lo_ff  <= {lo_ff[62:0], 1'b0};
               q_ff   <= {q_ff[62:0], sub_in};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= A_DFIN;
               end
            end
            A_DFIN: begin
               res_ff   <= from_mag(neg_ff, q_ff);
               state_ff <= A_IDLE;
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = res_ff;

   // A new operation is only issued while the unit is free.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> (state_ff == A_IDLE))
      else $error("alu started while busy");
   // Completion is a single-cycle pulse.
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("alu done held");
   // Divide loop always leaves through the finishing step.
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == A_DIV && cnt_ff == 6'd63) |=> (state_ff == A_DFIN))
      else $error("divide loop exit");

endmodule

/* hw/rtl/contact_normal_plastic_damage_unit.sv */
// Top level: sequencer, contact history memory and result register.
// Each transaction runs as a sequence of add, subtract, multiply and divide operations on the shared
// unit, whose divide is a 64-step loop unless it ends early on a zero operand or an overflow.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: synchronous; a clearing pass zeroes the contact history, no requests
// are taken during it; configuration registers return to their reset values at once.
`timescale 1ns / 1ps
module contact_normal_plastic_damage_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cnpd_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cnpd_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cnpd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cnpd_pkg::CFG_W-1:0]          csr_data
);
   import cnpd_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE, S_LOAD, S_FETCH,
      S_KB, S_KC, S_KD, S_PQ, S_KP, S_NY, S_N1, S_N2, S_N3, S_NT, S_FN, S_SIGN,
      S_CU1, S_CT2, S_CD2, S_CU2, S_CT3, S_CD3, S_CU3, S_CDEC,
      S_SGS, S_SGM, S_SGA, S_SGT,
      S_UPSEL, S_UPA, S_UPS, S_UPD, S_UPADD, S_UPDEC,
      S_PL1, S_PL2, S_PL3, S_PL4,
      S_TU1, S_TSP, S_TU2, S_TDEC, S_TA, S_TB, S_TC, S_TCL,
      S_TD, S_TE, S_TF, S_TG, S_TH,
      S_WB
   } state_type;

   typedef enum logic [4:0] {
      D_T, D_T2, D_KB, D_KC, D_KD, D_KP, D_NY, D_N1, D_N2, D_N3, D_NT,
      D_FN, D_U1, D_U2, D_U3, D_UP, D_TR
   } dst_type;

   typedef struct packed {
      q_type pi;
      q_type pf;
      q_type pd;
      q_type tr;
   } hist_type;

   // contact history memory
   hist_type mem [CONTACTS];
   hist_type rd_ff;

   state_type         state_ff;
   logic              issued_ff;
   logic [CIDX_W-1:0] clr_ff;
   req_type           req_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   q_type div2_ff, div3_ff, div4_ff, knee1_ff, knee2_ff, knee3_ff, yield_ff, tens_ff;
   q_type kb_ff, kc_ff, kd_ff, kp_ff, ny_ff, n1_ff, n2_ff, n3_ff, nt_ff, fn_ff;
   q_type u1_ff, u2_ff, u3_ff, t_ff, t2_ff, up_ff, ai_ff;
   q_type nseg_ff, useg_ff, kseg_ff;
   q_type pi_ff, pf_ff, pd_ff, tr_ff;
   logic  load_ff, written_ff, failed_ff;
   q_type dmg_ff;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic      is_op_in;
   alu_op_type op_in;
   q_type     a_in, b_in;
   dst_type   dst_in;
   state_type nxt_in;
   q_type     kn_in, em_in, area_in, pm_in, span_in, ind_in, ai_in, frac_in;
   logic      seg_hit_in;
   q_type     seg_n_in, seg_u_in, seg_k_in;
   logic      wb_fire_in;
   logic      mem_we_in;
   logic [CIDX_W-1:0] mem_addr_in;
   hist_type  mem_wdata_in;

   cnpd_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // zero-extend operand fields and pick the curve branch
   always_comb begin
      kn_in   = q_type'({1'b0, req_ff.elastic_stiffness});
      em_in   = q_type'({1'b0, req_ff.equivalent_modulus});
      area_in = q_type'({1'b0, req_ff.contact_area});
      pm_in   = q_type'({1'b0, req_ff.plastic_modulus});
      span_in = q_type'({1'b0, req_ff.damage_span_factor});
      ind_in  = req_ff.indentation;
      ai_in   = from_mag(1'b0, magof(ind_in));
      frac_in = (t_ff < 0) ? '0 : ((t_ff > ONE_Q) ? ONE_Q : t_ff);
      seg_hit_in = 1'b1;
      if (ind_in > u3_ff) begin
         seg_n_in = n3_ff; seg_u_in = u3_ff; seg_k_in = kd_ff;
      end else if (ind_in > u2_ff) begin
         seg_n_in = n2_ff; seg_u_in = u2_ff; seg_k_in = kc_ff;
      end else begin
         seg_n_in = n1_ff; seg_u_in = u1_ff; seg_k_in = kb_ff;
         seg_hit_in = ind_in > u1_ff;
      end
   end

   // operation table of the sequencer
   always_comb begin
      is_op_in = 1'b1;
      op_in    = ALU_DIV;
      a_in     = '0;
      b_in     = '0;
      dst_in   = D_T;
      nxt_in   = state_ff;
      case (state_ff)
         S_KB:    begin a_in = kn_in;   b_in = div2_ff; dst_in = D_KB; nxt_in = S_KC; end
         S_KC:    begin a_in = kn_in;   b_in = div3_ff; dst_in = D_KC; nxt_in = S_KD; end
         S_KD:    begin a_in = kn_in;   b_in = div4_ff; dst_in = D_KD; nxt_in = S_PQ; end
         S_PQ:    begin a_in = pm_in;   b_in = em_in;   dst_in = D_T;  nxt_in = S_KP; end
         S_KP:    begin op_in = ALU_MUL; a_in = t_ff; b_in = kn_in;
                        dst_in = D_KP; nxt_in = S_NY; end
         S_NY:    begin op_in = ALU_MUL; a_in = yield_ff; b_in = area_in;
                        dst_in = D_NY; nxt_in = S_N1; end
         S_N1:    begin op_in = ALU_MUL; a_in = knee1_ff; b_in = area_in;
                        dst_in = D_N1; nxt_in = S_N2; end
         S_N2:    begin op_in = ALU_MUL; a_in = knee2_ff; b_in = area_in;
                        dst_in = D_N2; nxt_in = S_N3; end
         S_N3:    begin op_in = ALU_MUL; a_in = knee3_ff; b_in = area_in;
                        dst_in = D_N3; nxt_in = S_NT; end
         S_NT:    begin op_in = ALU_MUL; a_in = tens_ff; b_in = area_in;
                        dst_in = D_NT; nxt_in = S_FN; end
         S_FN:    begin op_in = ALU_MUL; a_in = kn_in; b_in = ind_in;
                        dst_in = D_FN; nxt_in = S_SIGN; end
         S_CU1:   begin a_in = n1_ff; b_in = kn_in; dst_in = D_U1; nxt_in = S_CT2; end
         S_CT2:   begin op_in = ALU_SUB; a_in = n2_ff; b_in = n1_ff; nxt_in = S_CD2; end
         S_CD2:   begin a_in = t_ff; b_in = kb_ff; nxt_in = S_CU2; end
         S_CU2:   begin op_in = ALU_ADD; a_in = u1_ff; b_in = t_ff;
                        dst_in = D_U2; nxt_in = S_CT3; end
         S_CT3:   begin op_in = ALU_SUB; a_in = n3_ff; b_in = n2_ff; nxt_in = S_CD3; end
         S_CD3:   begin a_in = t_ff; b_in = kc_ff; nxt_in = S_CU3; end
         S_CU3:   begin op_in = ALU_ADD; a_in = u2_ff; b_in = t_ff;
                        dst_in = D_U3; nxt_in = S_CDEC; end
         S_SGS:   begin op_in = ALU_SUB; a_in = ind_in; b_in = useg_ff; nxt_in = S_SGM; end
         S_SGM:   begin op_in = ALU_MUL; a_in = t_ff; b_in = kseg_ff; nxt_in = S_SGA; end
         S_SGA:   begin op_in = ALU_ADD; a_in = nseg_ff; b_in = t_ff; dst_in = D_FN;
                        nxt_in = load_ff ? S_SGT : S_WB; end
         S_SGT:   begin a_in = kseg_ff; b_in = kn_in; dst_in = D_TR; nxt_in = S_WB; end
         S_UPA:   begin a_in = ny_ff; b_in = kn_in; dst_in = D_UP; nxt_in = S_UPDEC; end
         S_UPS:   begin op_in = ALU_SUB; a_in = ny_ff; b_in = nseg_ff; nxt_in = S_UPD; end
         S_UPD:   begin a_in = t_ff; b_in = kseg_ff; nxt_in = S_UPADD; end
         S_UPADD: begin op_in = ALU_ADD; a_in = useg_ff; b_in = t_ff;
                        dst_in = D_UP; nxt_in = S_UPDEC; end
         S_PL1:   begin op_in = ALU_SUB; a_in = pi_ff; b_in = ind_in; nxt_in = S_PL2; end
         S_PL2:   begin op_in = ALU_MUL; a_in = kp_ff; b_in = t_ff; nxt_in = S_PL3; end
         S_PL3:   begin op_in = ALU_SUB; a_in = pf_ff; b_in = t_ff;
                        dst_in = D_FN; nxt_in = S_PL4; end
         S_PL4:   begin a_in = kp_ff; b_in = kn_in; dst_in = D_TR; nxt_in = S_WB; end
         S_TU1:   begin a_in = nt_ff; b_in = kn_in; dst_in = D_U1; nxt_in = S_TSP; end
         S_TSP:   begin op_in = ALU_ADD; a_in = ONE_Q; b_in = span_in; nxt_in = S_TU2; end
         S_TU2:   begin op_in = ALU_MUL; a_in = u1_ff; b_in = t_ff;
                        dst_in = D_U2; nxt_in = S_TDEC; end
         S_TA:    begin op_in = ALU_SUB; a_in = ai_ff; b_in = u1_ff; nxt_in = S_TB; end
         S_TB:    begin op_in = ALU_SUB; a_in = u2_ff; b_in = u1_ff;
                        dst_in = D_T2; nxt_in = S_TC; end
         S_TC:    begin a_in = t_ff; b_in = t2_ff; nxt_in = S_TCL; end
         S_TD:    begin a_in = u1_ff; b_in = ai_ff; nxt_in = S_TE; end
         S_TE:    begin op_in = ALU_MUL; a_in = t_ff; b_in = kn_in; nxt_in = S_TF; end
         S_TF:    begin op_in = ALU_SUB; a_in = ONE_Q; b_in = pd_ff;
                        dst_in = D_T2; nxt_in = S_TG; end
         S_TG:    begin op_in = ALU_MUL; a_in = t_ff; b_in = t2_ff; nxt_in = S_TH; end
         S_TH:    begin op_in = ALU_MUL; a_in = t_ff; b_in = ind_in;
                        dst_in = D_FN; nxt_in = S_WB; end
         default: is_op_in = 1'b0;
      endcase
   end

   assign alu_req.start = is_op_in && !issued_ff;
   assign alu_req.op    = op_in;
   assign alu_req.a     = a_in;
   assign alu_req.b     = b_in;

   assign wb_fire_in   = (state_ff == S_WB) && (!rsp_valid_ff || rsp_ready);
   assign mem_we_in    = (state_ff == S_CLEAR) || wb_fire_in;
   assign mem_addr_in  = (state_ff == S_CLEAR) ? clr_ff : req_ff.contact_index;
   assign mem_wdata_in = (state_ff == S_CLEAR) ? hist_type'('0) :
                         hist_type'{pi: pi_ff, pf: (load_ff ? fn_ff : pf_ff),
                                    pd: pd_ff, tr: tr_ff};

   // history write and registered read
   always_ff @(posedge clock) begin
      if (mem_we_in) begin
         mem[mem_addr_in] <= mem_wdata_in;
      end
      rd_ff <= mem[req_ff.contact_index];
   end

   // sequencer, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         issued_ff    <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         div2_ff      <= ONE_Q;
         div3_ff      <= ONE_Q;
         div4_ff      <= ONE_Q;
         knee1_ff     <= '0;
         knee2_ff     <= '0;
         knee3_ff     <= '0;
         yield_ff     <= '0;
         tens_ff      <= ONE_Q;
      end else begin
         // drop the result once taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_ready && !wb_fire_in) begin
            rsp_valid_ff <= 1'b0;
         end
         // configuration writes
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_SLOPE_DIV_TWO:   div2_ff  <= q_type'({1'b0, csr_data});
               CSR_SLOPE_DIV_THREE: div3_ff  <= q_type'({1'b0, csr_data});
               CSR_SLOPE_DIV_FOUR:  div4_ff  <= q_type'({1'b0, csr_data});
               CSR_KNEE_ONE:        knee1_ff <= q_type'({1'b0, csr_data});
               CSR_KNEE_TWO:        knee2_ff <= q_type'({1'b0, csr_data});
               CSR_KNEE_THREE:      knee3_ff <= q_type'({1'b0, csr_data});
               CSR_YIELD:           yield_ff <= q_type'({1'b0, csr_data});
               CSR_TENSILE:         tens_ff  <= q_type'({1'b0, csr_data});
               default: ;
            endcase
         end
         // issue to the shared unit, capture on completion
         if (is_op_in) begin
            if (!issued_ff) begin
               issued_ff <= 1'b1;
            end else if (alu_rsp.done) begin
               issued_ff <= 1'b0;
               state_ff  <= nxt_in;
               case (dst_in)
                  D_T:  t_ff  <= alu_rsp.result;
                  D_T2: t2_ff <= alu_rsp.result;
                  D_KB: kb_ff <= alu_rsp.result;
                  D_KC: kc_ff <= alu_rsp.result;
                  D_KD: kd_ff <= alu_rsp.result;
                  D_KP: kp_ff <= alu_rsp.result;
                  D_NY: ny_ff <= alu_rsp.result;
                  D_N1: n1_ff <= alu_rsp.result;
                  D_N2: n2_ff <= alu_rsp.result;
                  D_N3: n3_ff <= alu_rsp.result;
                  D_NT: nt_ff <= alu_rsp.result;
                  D_FN: fn_ff <= alu_rsp.result;
                  D_U1: u1_ff <= alu_rsp.result;
                  D_U2: u2_ff <= alu_rsp.result;
                  D_U3: u3_ff <= alu_rsp.result;
                  D_UP: up_ff <= alu_rsp.result;
                  D_TR: tr_ff <= alu_rsp.result;
                  default: ;
               endcase
            end
         end else begin
            case (state_ff)
               S_CLEAR: begin
                  clr_ff <= clr_ff + 1'b1;
                  if (clr_ff == {CIDX_W{1'b1}}) begin
                     state_ff <= S_IDLE;
                  end
               end
               S_IDLE: begin
                  if (req_valid) begin
                     req_ff     <= req_payload;
                     load_ff    <= 1'b0;
                     written_ff <= 1'b0;
                     failed_ff  <= 1'b0;
                     dmg_ff     <= '0;
                     state_ff   <= S_LOAD;
                  end
               end
               S_LOAD: state_ff <= S_FETCH;
               S_FETCH: begin
                  pi_ff    <= rd_ff.pi;
                  pf_ff    <= rd_ff.pf;
                  pd_ff    <= rd_ff.pd;
                  tr_ff    <= rd_ff.tr;
                  state_ff <= S_KB;
               end
               S_SIGN: state_ff <= ind_in[DATA_W-1] ? S_TU1 : S_CU1;
               // loading past the peak or on the first step, or unloading below it
               S_CDEC: begin
                  if ((ind_in > pi_ff) || req_ff.first_step) begin
                     load_ff  <= 1'b1;
                     pi_ff    <= ind_in;
                     nseg_ff  <= seg_n_in;
                     useg_ff  <= seg_u_in;
                     kseg_ff  <= seg_k_in;
                     state_ff <= seg_hit_in ? S_SGS : S_WB;
                  end else if (pf_ff > 0) begin
                     state_ff <= S_UPSEL;
                  end else begin
                     state_ff <= S_WB;
                  end
               end
               // yield overlap on the loading curve
               S_UPSEL: begin
                  if (ny_ff <= n1_ff) begin
                     state_ff <= S_UPA;
                  end else begin
                     if (ny_ff <= n2_ff) begin
                        nseg_ff <= n1_ff; useg_ff <= u1_ff; kseg_ff <= kb_ff;
                     end else if (ny_ff <= n3_ff) begin
                        nseg_ff <= n2_ff; useg_ff <= u2_ff; kseg_ff <= kc_ff;
                     end else begin
                        nseg_ff <= n3_ff; useg_ff <= u3_ff; kseg_ff <= kd_ff;
                     end
                     state_ff <= S_UPS;
                  end
               end
               S_UPDEC: begin
                  if (up_ff < pi_ff) begin
                     state_ff <= S_PL1;
                  end else begin
                     nseg_ff  <= seg_n_in;
                     useg_ff  <= seg_u_in;
                     kseg_ff  <= seg_k_in;
                     state_ff <= seg_hit_in ? S_SGS : S_WB;
                  end
               end
               // tension: full failure, softening or elastic
               S_TDEC: begin
                  ai_ff <= ai_in;
                  if (ai_in > u2_ff) begin
                     failed_ff  <= 1'b1;
                     written_ff <= 1'b1;
                     dmg_ff     <= ONE_Q;
                     fn_ff      <= '0;
                     state_ff   <= S_WB;
                  end else if (ai_in > u1_ff) begin
                     state_ff <= S_TA;
                  end else begin
                     state_ff <= S_WB;
                  end
               end
               S_TCL: begin
                  dmg_ff     <= frac_in;
                  written_ff <= 1'b1;
                  if (frac_in > pd_ff) begin
                     pd_ff <= frac_in;
                  end
                  state_ff <= S_TD;
               end
               S_WB: begin
                  if (wb_fire_in) begin
                     rsp_valid_ff           <= 1'b1;
                     rsp_ff.normal_force    <= fn_ff;
                     rsp_ff.stiffness_ratio <= tr_ff;
                     rsp_ff.damage          <= dmg_ff[32:0];
                     rsp_ff.damage_written  <= written_ff;
                     rsp_ff.tension_failure <= failed_ff;
                     state_ff               <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // An accepted transaction closes the input until it is finished.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while busy");
   // Results from the shared unit only arrive for an issued operation.
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> issued_ff)
      else $error("unexpected alu completion");
   // Full failure always reports full written damage.
   a_fail_damage: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.tension_failure) |->
         (rsp_ff.damage_written && (rsp_ff.damage == ONE_Q[32:0])))
      else $error("failure without full damage");
   // No result while the history is being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");

endmodule
